### sv/assert_macros.svh
// Assertion macros shared by the checker.
// Plain property wrappers: clock, reset, antecedent, consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLY(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

### sv/jmv_pkg.sv
// Package for the JSON message validator: phase codes, status codes,
// name tables and helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jmv_pkg;

	typedef enum logic [3:0] {
		PH_START, PH_OBJ_OPEN, PH_AFTER_COMMA, PH_KEY, PH_AFTER_KEY,
		PH_BEFORE_VALUE, PH_VALUE_STR, PH_NUMBER, PH_AFTER_VALUE, PH_DONE, PH_HALT
	} phase_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_LARGE = 3'd1;
	localparam logic [2:0] ST_BAD_UTF8  = 3'd2;
	localparam logic [2:0] ST_BAD_JSON  = 3'd3;
	localparam logic [2:0] ST_MISSING   = 3'd4;
	localparam logic [2:0] ST_BAD_TYPE  = 3'd5;

	localparam int NKEYS  = 3;
	localparam int NTYPES = 12;

	localparam bit [55:0] KEY_NAMES [NKEYS] = '{"type", "session", "client"};
	localparam bit [2:0]  KEY_LENS  [NKEYS] = '{3'd4, 3'd7, 3'd6};

	localparam bit [103:0] TYPE_NAMES [NTYPES] = '{
		"HELLO", "JOIN", "JOIN_OK", {"JOIN_", "FAIL"}, "INSERT", "DELETE", "APPLY",
		{"SYNC_", "REQUEST"}, {"SYNC_", "RESPONSE"}, "PING", "PONG", "ERROR"};
	localparam bit [3:0] TYPE_LENS [NTYPES] = '{4'd5, 4'd4, 4'd7, 4'd9, 4'd6, 4'd6,
		4'd5, 4'd12, 4'd13, 4'd4, 4'd4, 4'd5};

	typedef struct packed {
		logic        cp_valid;
		logic [20:0] cp;
		logic        bad;
		logic        open;
	} utf8_res_t;

	typedef struct packed {
		logic [2:0] first_error;
		logic       done;
		logic [3:0] type_seen;
		logic       session;
		logic       client;
	} parse_res_t;

	// character at position p of a key name; caller checks p < length
	function automatic logic [7:0] key_char(input int i, input logic [2:0] p);
		int idx;
		idx = int'(KEY_LENS[i]) - 1 - int'(p);
		if (idx < 0) idx = 0;
		return KEY_NAMES[i][idx*8 +: 8];
	endfunction

	function automatic logic [7:0] type_char(input int i, input logic [3:0] p);
		int idx;
		idx = int'(TYPE_LENS[i]) - 1 - int'(p);
		if (idx < 0) idx = 0;
		return TYPE_NAMES[i][idx*8 +: 8];
	endfunction

	function automatic logic is_ws(input logic [20:0] c);
		return c == 21'h20 || c == 21'h09 || c == 21'h0D || c == 21'h0A;
	endfunction

endpackage
`default_nettype wire

### sv/jmv_if.sv
// Channel interfaces for the validator: byte input, result output, config write.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface jmv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last;
	modport source (output valid, payload_byte, last, input ready);
	modport sink   (input valid, payload_byte, last, output ready);
endinterface

interface jmv_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] message_type;
	modport source (output valid, status, message_type, input ready);
	modport sink   (input valid, status, message_type, output ready);
endinterface

interface jmv_cfg_if;
	logic        valid;
	logic        ready;
	logic [23:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### sv/jmv_utf8.sv
// Strict UTF-8 decoder: one byte per request, emits completed code points.
// Depends on jmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jmv_utf8 import jmv_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic       clr,
	input  wire logic [7:0] byte_in,
	output utf8_res_t       res
);
	logic [1:0]  pend_q, pend_n;
	logic [1:0]  len_q, len_n;	// 1: two-byte, 2: three-byte, 3: four-byte
	logic [20:0] cp_q, cp_n;
	logic        bad_q, bad_n;
	logic        cpv;
	logic [20:0] cpo;

	always_comb begin
		pend_n = pend_q;
		len_n  = len_q;
		cp_n   = cp_q;
		bad_n  = bad_q;
		cpv    = 1'b0;
		cpo    = {13'd0, byte_in};
		if (!bad_q) begin
			if (pend_q == 2'd0) begin
				if (byte_in < 8'h80) begin
					cpv = 1'b1;
				end else if (byte_in >= 8'hC2 && byte_in <= 8'hDF) begin
					pend_n = 2'd1; len_n = 2'd1; cp_n = {16'd0, byte_in[4:0]};
				end else if (byte_in >= 8'hE0 && byte_in <= 8'hEF) begin
					pend_n = 2'd2; len_n = 2'd2; cp_n = {17'd0, byte_in[3:0]};
				end else if (byte_in >= 8'hF0 && byte_in <= 8'hF4) begin
					pend_n = 2'd3; len_n = 2'd3; cp_n = {18'd0, byte_in[2:0]};
				end else begin
					bad_n = 1'b1;
				end
			end else if (byte_in[7:6] != 2'b10) begin
				bad_n = 1'b1;
			end else begin
				cp_n   = {cp_q[14:0], byte_in[5:0]};
				pend_n = pend_q - 2'd1;
				cpo    = cp_n;
				if (pend_n == 2'd0) begin
					if (len_q == 2'd2 && (cp_n < 21'h800 ||
						(cp_n >= 21'hD800 && cp_n <= 21'hDFFF)))
						bad_n = 1'b1;
					else if (len_q == 2'd3 && (cp_n < 21'h10000 || cp_n > 21'h10FFFF))
						bad_n = 1'b1;
					else
						cpv = 1'b1;
				end
			end
		end
	end

	assign res.cp_valid = cpv;
	assign res.cp       = cpo;
	assign res.bad      = bad_n;
	assign res.open     = pend_n != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0; len_q <= '0; cp_q <= '0; bad_q <= 1'b0;
		end else if (step) begin
			if (clr) begin
				pend_q <= '0; len_q <= '0; cp_q <= '0; bad_q <= 1'b0;
			end else begin
				pend_q <= pend_n; len_q <= len_n; cp_q <= cp_n; bad_q <= bad_n;
			end
		end
	end
endmodule
`default_nettype wire

### sv/jmv_parser.sv
// Flat JSON object parser over code points, with key and type-name matching.
// Depends on jmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jmv_parser import jmv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        clr,
	input  wire logic        cp_valid,
	input  wire logic [20:0] c,
	output parse_res_t       res
);
	phase_t       ph_q, ph_n;
	logic         esc_q, esc_n;
	logic [2:0]   ferr_q, ferr_n;
	logic [2:0]   kc_q, kc_n;
	logic [2:0]   kp_q, kp_n;
	logic [11:0]  vc_q, vc_n;
	logic [3:0]   vp_q, vp_n;
	logic [63:0]  num_q, num_n;
	logic [3:0]   typ_q, typ_n;
	logic         sess_q, sess_n, cli_q, cli_n;

	logic [20:0]  d, mc;
	logic         esc_ok, digit, ovf;
	logic [2:0]   kc_a, kc_c;
	logic [11:0]  vc_a;
	logic [3:0]   typ_c;
	logic [67:0]  num_t;

	always_comb begin
		esc_ok = 1'b1;
		unique case (c)
			21'h22, 21'h5C, 21'h2F: d = c;
			21'h62: d = 21'h08;
			21'h66: d = 21'h0C;
			21'h6E: d = 21'h0A;
			21'h72: d = 21'h0D;
			21'h74: d = 21'h09;
			default: begin d = c; esc_ok = 1'b0; end
		endcase
		mc = esc_q ? d : c;
		for (int i = 0; i < NKEYS; i++) begin
			kc_a[i] = kc_q[i] && kp_q < KEY_LENS[i] && mc == {13'd0, key_char(i, kp_q)};
			kc_c[i] = kc_q[i] && kp_q == KEY_LENS[i];
		end
		typ_c = '0;
		for (int i = 0; i < NTYPES; i++) begin
			vc_a[i] = vc_q[i] && vp_q < TYPE_LENS[i] && mc == {13'd0, type_char(i, vp_q)};
			if (vc_q[i] && vp_q == TYPE_LENS[i]) typ_c = 4'(i + 1);
		end
		digit = c >= 21'h30 && c <= 21'h39;
		num_t = ({4'd0, num_q} << 3) + ({4'd0, num_q} << 1) + {64'd0, c[3:0]};
		ovf   = num_t[67:64] != 4'd0;
	end

	always_comb begin
		ph_n = ph_q; esc_n = esc_q; ferr_n = ferr_q; kc_n = kc_q; kp_n = kp_q;
		vc_n = vc_q; vp_n = vp_q; num_n = num_q; typ_n = typ_q;
		sess_n = sess_q; cli_n = cli_q;
		if (cp_valid) begin
			unique case (ph_q)
				PH_START: begin
					if (!is_ws(c)) begin
						if (c == 21'h7B) ph_n = PH_OBJ_OPEN;
						else begin ferr_n = ST_BAD_JSON; ph_n = PH_HALT; end
					end
				end
				PH_OBJ_OPEN, PH_AFTER_COMMA: begin
					if (!is_ws(c)) begin
						if (c == 21'h7D) begin
							ferr_n = (ph_q == PH_OBJ_OPEN) ? ST_MISSING : ST_BAD_JSON;
							ph_n = PH_HALT;
						end else if (c == 21'h22) begin
							kc_n = 3'b111; kp_n = '0; esc_n = 1'b0; ph_n = PH_KEY;
						end else begin ferr_n = ST_BAD_JSON; ph_n = PH_HALT; end
					end
				end
				PH_KEY, PH_VALUE_STR: begin
					if (esc_q && !esc_ok) begin
						esc_n = 1'b0; ferr_n = ST_BAD_JSON; ph_n = PH_HALT;
					end else if (!esc_q && c == 21'h22) begin
						if (ph_q == PH_KEY) begin
							kc_n = kc_c; kp_n = '0; ph_n = PH_AFTER_KEY;
						end else begin
							if (kc_q[0]) typ_n = typ_c;
							else if (kc_q[1]) sess_n = vp_q != '0;
							else if (kc_q[2]) cli_n = vp_q != '0;
							ph_n = PH_AFTER_VALUE;
						end
					end else if (!esc_q && c == 21'h5C) begin
						esc_n = 1'b1;
					end else begin
						esc_n = 1'b0;
						if (ph_q == PH_KEY) begin
							kc_n = kc_a;
							if (kp_q != 3'd7) kp_n = kp_q + 3'd1;
						end else begin
							vc_n = vc_a;
							if (vp_q != 4'd15) vp_n = vp_q + 4'd1;
						end
					end
				end
				PH_AFTER_KEY: begin
					if (!is_ws(c)) begin
						if (c == 21'h3A) ph_n = PH_BEFORE_VALUE;
						else begin ferr_n = ST_BAD_JSON; ph_n = PH_HALT; end
					end
				end
				PH_BEFORE_VALUE: begin
					if (!is_ws(c)) begin
						if (c == 21'h22) begin
							vc_n = 12'hFFF; vp_n = '0; esc_n = 1'b0; ph_n = PH_VALUE_STR;
						end else if (digit) begin
							num_n = {60'd0, c[3:0]}; ph_n = PH_NUMBER;
						end else begin ferr_n = ST_BAD_JSON; ph_n = PH_HALT; end
					end
				end
				PH_NUMBER, PH_AFTER_VALUE: begin
					if (ph_q == PH_NUMBER && digit) begin
						if (ovf) begin ferr_n = ST_BAD_JSON; ph_n = PH_HALT; end
						else num_n = num_t[63:0];
					end else begin
						ph_n = PH_AFTER_VALUE;
						if (!is_ws(c)) begin
							if (c == 21'h7D) ph_n = PH_DONE;
							else if (c == 21'h2C) ph_n = PH_AFTER_COMMA;
							else begin ferr_n = ST_BAD_JSON; ph_n = PH_HALT; end
						end
					end
				end
				PH_DONE: begin
					if (!is_ws(c)) begin ferr_n = ST_BAD_JSON; ph_n = PH_HALT; end
				end
				default: ;
			endcase
		end
	end

	assign res.first_error = ferr_n;
	assign res.done        = ph_n == PH_DONE;
	assign res.type_seen   = typ_n;
	assign res.session     = sess_n;
	assign res.client      = cli_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_START; esc_q <= 1'b0; ferr_q <= ST_OK; kc_q <= '0; kp_q <= '0;
			vc_q <= '0; vp_q <= '0; typ_q <= '0; sess_q <= 1'b0; cli_q <= 1'b0;
		end else if (step) begin
			if (clr) begin
				ph_q <= PH_START; esc_q <= 1'b0; ferr_q <= ST_OK; kc_q <= '0; kp_q <= '0;
				vc_q <= '0; vp_q <= '0; typ_q <= '0; sess_q <= 1'b0; cli_q <= 1'b0;
			end else begin
				ph_q <= ph_n; esc_q <= esc_n; ferr_q <= ferr_n; kc_q <= kc_n;
				kp_q <= kp_n; vc_q <= vc_n; vp_q <= vp_n; typ_q <= typ_n;
				sess_q <= sess_n; cli_q <= cli_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) num_q <= '0;
		else if (step) num_q <= clr ? '0 : num_n;
	end
endmodule
`default_nettype wire

### sv/json_message_validator_core.sv
// JSON message validator top level: length check, UTF-8 decode, parse, result register.
// Depends on jmv_pkg, jmv_if, jmv_utf8, jmv_parser.
//
// Usage:
//  rx carries one payload byte per request, with last on the final byte.
//  tx carries one result (status, message_type) per payload, after its last byte.
//  cfg writes max_payload_bytes; it is always ready and is meant for idle periods.
// Throughput: one byte per cycle while rx.ready is high. The decoder and parser
//  advance their state on each accepted byte.
// The result is registered; tx.valid rises the cycle after the last byte is accepted.
// Stall: the result register holds while tx.ready is low; rx.ready drops only
//  while a result waits and is not being taken, so a taken result frees the
//  register in the same cycle for the next one.
// Reset: arst_n clears all per-payload state, empties the result register and
//  sets max_payload_bytes to 1048576. Byte counting saturates at 2^LENGTH_BITS-1.
`timescale 1ns / 1ps
`default_nettype none
module json_message_validator_core import jmv_pkg::*; #(
	parameter int LENGTH_BITS = 24
) (
	input wire logic  clk,
	input wire logic  arst_n,
	jmv_cfg_if.sink   cfg,
	jmv_in_if.sink    rx,
	jmv_out_if.source tx
);
	localparam int CW = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;

	logic [23:0]            max_q;
	logic [LENGTH_BITS-1:0] cnt_q;
	logic                   over_q, over_n;
	logic                   accept, rdy;
	logic                   ovalid_q;
	logic [2:0]             status_q, st;
	logic [3:0]             mtype_q, mt;
	utf8_res_t              ures;
	parse_res_t             pres;

	assign cfg.ready = 1'b1;
	assign rdy       = !ovalid_q || tx.ready;
	assign rx.ready  = rdy;
	assign accept    = rx.valid && rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_q <= 24'd1048576;
		else if (cfg.valid) max_q <= cfg.data;
	end

	assign over_n = over_q || (CW'(cnt_q) >= CW'(max_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; over_q <= 1'b0;
		end else if (accept) begin
			if (rx.last) begin
				cnt_q <= '0; over_q <= 1'b0;
			end else begin
				over_q <= over_n;
				if (cnt_q != '1) cnt_q <= cnt_q + LENGTH_BITS'(1);
			end
		end
	end

	jmv_utf8 u_utf8 (
		.clk(clk), .arst_n(arst_n), .step(accept), .clr(rx.last),
		.byte_in(rx.payload_byte), .res(ures)
	);

	jmv_parser u_parser (
		.clk(clk), .arst_n(arst_n), .step(accept), .clr(rx.last),
		.cp_valid(ures.cp_valid), .c(ures.cp), .res(pres)
	);

	always_comb begin
		mt = '0;
		priority if (over_n)                     st = ST_TOO_LARGE;
		else if (ures.bad || ures.open)          st = ST_BAD_UTF8;
		else if (pres.first_error != ST_OK)      st = pres.first_error;
		else if (!pres.done)                     st = ST_BAD_JSON;
		else if (pres.type_seen == '0)           st = ST_BAD_TYPE;
		else if (!pres.session || !pres.client)  st = ST_MISSING;
		else begin st = ST_OK; mt = pres.type_seen; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (accept && rx.last) ovalid_q <= 1'b1;
		else if (tx.ready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept && rx.last) begin
			status_q <= st;
			mtype_q  <= mt;
		end
	end

	assign tx.valid        = ovalid_q;
	assign tx.status       = status_q;
	assign tx.message_type = mtype_q;
endmodule
`default_nettype wire

### sv/jmv_checker.sv
// Port-level checks for the validator, bound to the top level.
// Depends on assert_macros.svh and json_message_validator_core.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jmv_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rx_valid,
	input wire logic       rx_ready,
	input wire logic       rx_last,
	input wire logic       tx_valid,
	input wire logic       tx_ready,
	input wire logic [2:0] tx_status,
	input wire logic [3:0] tx_message_type
);
	`AST_NEXT(a_tx_hold, clk, arst_n, tx_valid && !tx_ready, tx_valid)
	`AST_IMPLY(a_type_zero, clk, arst_n, tx_valid && tx_status != 3'd0, tx_message_type == 4'd0)
	`AST_IMPLY(a_no_take_full, clk, arst_n, tx_valid && !tx_ready, !rx_ready)
	`AST_IMPLY(a_from_last, clk, arst_n, $rose(tx_valid), $past(rx_valid && rx_ready && rx_last))
endmodule

bind json_message_validator_core jmv_checker u_jmv_checker (
	.clk(clk), .arst_n(arst_n),
	.rx_valid(rx.valid), .rx_ready(rx.ready), .rx_last(rx.last),
	.tx_valid(tx.valid), .tx_ready(tx.ready),
	.tx_status(tx.status), .tx_message_type(tx.message_type)
);
`default_nettype wire
